>>> sv/rla_pkg.sv
// Shared types and constants of the rotating LED ring animator.
package rla_pkg;

  typedef enum logic [2:0] {
    CMD_CONFIGURE  = 3'd0,
    CMD_POWER      = 3'd1,
    CMD_SELECT     = 3'd2,
    CMD_DESELECT   = 3'd3,
    CMD_DISCONNECT = 3'd4,
    CMD_TICK       = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ACTIVE_LEDS      = 3'd0,
    REG_RELAY_ON         = 3'd1,
    REG_PERSON_NEAR      = 3'd2,
    REG_THRESHOLD_GREEN  = 3'd3,
    REG_THRESHOLD_YELLOW = 3'd4,
    REG_THRESHOLD_RED    = 3'd5
  } reg_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_BLANK = 7'b0000010,
    ST_NBR   = 7'b0000100,
    ST_DRAW  = 7'b0001000,
    ST_STEP  = 7'b0010000,
    ST_SHOW  = 7'b0100000,
    ST_TABLE = 7'b1000000
  } state_t;

  localparam logic [23:0] COL_PURPLE = 24'h660066;
  localparam logic [23:0] COL_GREEN  = 24'h00FF00;
  localparam logic [23:0] COL_YELLOW = 24'hFFFF00;
  localparam logic [23:0] COL_RED    = 24'hFF0000;
  localparam logic [23:0] COL_BLACK  = 24'h000000;

  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_BWD = 2'd2;

endpackage

>>> sv/rotating_led_ring_animator_unit.sv
// Top level of the rotating LED ring animator: LED table and command sequencer.
// Configure completes without leaving idle; power, select and deselect walk the table over the active LEDs.
// Disconnect writes RING_SIZE black pixel words, one pixel word a cycle, then a last marker and a table clear.
// Tick: each moving LED scans the c configured LEDs for its neighbour pixel, then all LEDs step.
// One word at a time; busy stays high until the word sequence ends; receiver cannot stall.
// Reset clears the table (not the backup colours), the LED count and the registers (active_leds to 1).
module rotating_led_ring_animator_unit
  import rla_pkg::*;
#(
  parameter int MAX_LEDS  = 8,
  parameter int RING_SIZE = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [3:0]  in_start_position,
  input  logic [1:0]  in_direction,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic signed [31:0] in_power_value,
  input  logic [2:0]  in_led_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        out_strobe,
  output logic [3:0]  out_pixel_index,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_write_valid,
  output logic        out_heartbeat,
  output logic        out_last
);

  localparam int IW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(MAX_LEDS + 1);
  localparam int PW = $clog2(RING_SIZE);
  localparam logic [PW-1:0] RING_LAST = PW'(RING_SIZE - 1);

  logic [PW-1:0] pos_r   [MAX_LEDS];
  logic [PW-1:0] start_r [MAX_LEDS];
  logic [1:0]    dir_r   [MAX_LEDS];
  logic [23:0]   col_r   [MAX_LEDS];
  logic [23:0]   bak_r   [MAX_LEDS];
  logic [MAX_LEDS-1:0] sel_r;
  logic [CW-1:0] cnt_r;
  logic          run_r;

  logic [3:0]  active_r;
  logic        relay_r, near_r;
  logic signed [31:0] thg_r, thy_r, thr_r;

  state_t      st_r;
  logic [2:0]  cmd_r;
  logic [23:0] pcol_r;
  logic [23:0] scol_r;
  logic [2:0]  idx_r;
  logic [IW-1:0] i_r, j_r;
  logic [PW-1:0] nb_r;
  logic          occ_r;
  logic [PW:0]   blank_r;

  logic [CW-1:0] n;
  assign n = (CW'(active_r) > CW'(MAX_LEDS)) ? CW'(MAX_LEDS) : CW'(active_r);

  logic [3:0] sp_mod;
  logic [3:0] sp_tab [16];
  for (genvar g = 0; g < 16; g++) begin : g_sp_tab
    assign sp_tab[g] = 4'(g % RING_SIZE);
  end
  assign sp_mod = sp_tab[in_start_position];

  logic [23:0] pwr_col;
  always_comb begin
    priority if (near_r && !relay_r) pwr_col = COL_PURPLE;
    else if (near_r && in_power_value < thg_r) pwr_col = COL_GREEN;
    else if (near_r && in_power_value < thy_r) pwr_col = COL_YELLOW;
    else if (near_r && in_power_value > thr_r) pwr_col = COL_RED;
    else pwr_col = COL_BLACK;
  end

  logic last_i, last_j;
  assign last_i = (CW'(i_r) + 1'b1 >= n);
  assign last_j = (CW'(j_r) + 1'b1 >= cnt_r);

  logic [PW-1:0] cur_pos;
  logic [1:0]    cur_dir;
  assign cur_pos = pos_r[i_r];
  assign cur_dir = dir_r[i_r];

  logic [PW-1:0] nb_calc;
  always_comb begin
    if (cur_dir == DIR_FWD) nb_calc = (cur_pos == '0) ? RING_LAST : cur_pos - 1'b1;
    else nb_calc = (cur_pos == RING_LAST) ? '0 : cur_pos + 1'b1;
  end

  logic [PW-1:0] nb_cmp;
  logic          nb_hit, nb_free, moving;
  assign nb_cmp = (j_r == '0) ? nb_calc : nb_r;
  assign nb_hit = (CW'(j_r) < cnt_r) && (pos_r[j_r] == nb_cmp);
  assign nb_free = !(occ_r || nb_hit);
  assign moving = (cur_dir == DIR_FWD) || (cur_dir == DIR_BWD);

  logic idx_ok;
  assign idx_ok = (CW'(in_led_index) < n) && (32'(in_led_index) < MAX_LEDS);

  assign busy = (st_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe <= 1'b0;
      out_heartbeat <= 1'b0;
      out_last <= 1'b0;
      st_r <= ST_IDLE;
      active_r <= 4'd1; relay_r <= 1'b0; near_r <= 1'b0;
      thg_r <= '0; thy_r <= '0; thr_r <= '0;
      cnt_r <= '0; run_r <= 1'b0; sel_r <= '0;
      for (int k = 0; k < MAX_LEDS; k++) begin
        pos_r[k] <= '0; start_r[k] <= '0; dir_r[k] <= '0; col_r[k] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ACTIVE_LEDS:      active_r <= cfg_data[3:0];
          REG_RELAY_ON:         relay_r <= cfg_data[0];
          REG_PERSON_NEAR:      near_r <= cfg_data[0];
          REG_THRESHOLD_GREEN:  thg_r <= cfg_data;
          REG_THRESHOLD_YELLOW: thy_r <= cfg_data;
          REG_THRESHOLD_RED:    thr_r <= cfg_data;
          default: ;
        endcase
      end
      unique case (st_r)
        ST_IDLE: begin
          out_strobe <= 1'b0;
          out_heartbeat <= 1'b0;
          out_last <= 1'b0;
          if (start) begin
            cmd_r <= in_command;
            idx_r <= in_led_index;
            i_r <= '0;
            unique case (in_command)
              CMD_CONFIGURE: begin
                if (cnt_r < n) begin
                  pos_r[cnt_r[IW-1:0]] <= PW'(sp_mod);
                  start_r[cnt_r[IW-1:0]] <= PW'(sp_mod);
                  dir_r[cnt_r[IW-1:0]] <= in_direction;
                  col_r[cnt_r[IW-1:0]] <= {in_red_in, in_green_in, in_blue_in};
                  sel_r[cnt_r[IW-1:0]] <= 1'b0;
                  cnt_r <= cnt_r + 1'b1;
                  if (cnt_r + 1'b1 >= n) run_r <= 1'b1;
                end
              end
              CMD_POWER: begin
                pcol_r <= pwr_col;
                if (n != '0) st_r <= ST_TABLE;
              end
              CMD_SELECT, CMD_DESELECT: begin
                if (idx_ok) begin
                  scol_r <= col_r[in_led_index[IW-1:0]];
                  st_r <= ST_TABLE;
                end
              end
              CMD_DISCONNECT: begin
                run_r <= 1'b0;
                blank_r <= '0;
                st_r <= ST_BLANK;
              end
              CMD_TICK: begin
                if (run_r) st_r <= (n != '0) ? ST_NBR : ST_SHOW;
              end
              default: ;
            endcase
          end
        end
        ST_TABLE: begin
          out_strobe <= 1'b0;
          out_heartbeat <= 1'b0;
          out_last <= 1'b0;
          unique case (cmd_r)
            CMD_POWER:  if (!sel_r[i_r]) col_r[i_r] <= pcol_r;
            CMD_SELECT: begin
              bak_r[i_r] <= col_r[i_r];
              col_r[i_r] <= scol_r;
            end
            default: col_r[i_r] <= bak_r[i_r];
          endcase
          if (last_i) begin
            st_r <= ST_IDLE;
            if (cmd_r == CMD_SELECT) sel_r[idx_r[IW-1:0]] <= 1'b1;
            if (cmd_r == CMD_DESELECT) sel_r[idx_r[IW-1:0]] <= 1'b0;
          end
          i_r <= i_r + 1'b1;
        end
        ST_BLANK: begin
          out_strobe <= 1'b1;
          out_heartbeat <= 1'b0;
          out_red_out <= '0; out_green_out <= '0; out_blue_out <= '0;
          if (blank_r == (PW+1)'(RING_SIZE)) begin
            out_pixel_index <= '0;
            out_write_valid <= 1'b0;
            out_last <= 1'b1;
            st_r <= ST_IDLE;
            cnt_r <= '0; sel_r <= '0;
            for (int k = 0; k < MAX_LEDS; k++) begin
              pos_r[k] <= '0; start_r[k] <= '0; dir_r[k] <= '0; col_r[k] <= '0;
            end
          end else begin
            out_pixel_index <= 4'(blank_r);
            out_write_valid <= 1'b1;
            out_last <= 1'b0;
          end
          blank_r <= blank_r + 1'b1;
        end
        ST_NBR: begin
          out_heartbeat <= 1'b0;
          out_last <= 1'b0;
          if (!moving) begin
            out_strobe <= 1'b0;
            if (last_i) begin
              i_r <= '0; st_r <= ST_STEP;
            end else i_r <= i_r + 1'b1;
          end else begin
            out_strobe <= last_j && nb_free;
            out_pixel_index <= 4'(nb_cmp);
            out_red_out <= '0; out_green_out <= '0; out_blue_out <= '0;
            out_write_valid <= 1'b1;
            if (j_r == '0 && !occ_r) nb_r <= nb_calc;
            if (nb_hit) occ_r <= 1'b1;
            if (last_j) begin
              j_r <= '0;
              st_r <= ST_DRAW;
            end else j_r <= j_r + 1'b1;
          end
        end
        ST_DRAW: begin
          occ_r <= 1'b0;
          out_strobe <= 1'b1;
          out_heartbeat <= 1'b0;
          out_last <= 1'b0;
          out_pixel_index <= 4'(cur_pos);
          {out_red_out, out_green_out, out_blue_out} <= col_r[i_r];
          out_write_valid <= 1'b1;
          if (last_i) begin
            i_r <= '0; st_r <= ST_STEP;
          end else begin
            i_r <= i_r + 1'b1; st_r <= ST_NBR;
          end
        end
        ST_STEP: begin
          out_strobe <= 1'b0;
          out_heartbeat <= 1'b0;
          out_last <= 1'b0;
          if (cur_dir == DIR_FWD)
            pos_r[i_r] <= (cur_pos >= RING_LAST) ? '0 : cur_pos + 1'b1;
          else if (cur_dir == DIR_BWD)
            pos_r[i_r] <= (cur_pos == '0 || cur_pos > RING_LAST) ? RING_LAST
                                                                : cur_pos - 1'b1;
          if (last_i) st_r <= ST_SHOW;
          i_r <= i_r + 1'b1;
        end
        ST_SHOW: begin
          out_strobe <= 1'b1;
          out_pixel_index <= '0;
          out_red_out <= '0; out_green_out <= '0; out_blue_out <= '0;
          out_write_valid <= 1'b0;
          out_heartbeat <= (pos_r[0] == start_r[0]);
          out_last <= 1'b1;
          st_r <= ST_IDLE;
        end
        default: begin
          out_strobe <= 1'b0;
          out_heartbeat <= 1'b0;
          out_last <= 1'b0;
          st_r <= ST_IDLE;
        end
      endcase
      if (st_r == ST_IDLE) begin
        occ_r <= 1'b0; j_r <= '0;
      end
    end
  end

endmodule

>>> sv/rla_checker.sv
// Port-level checker of the rotating LED ring animator, bound to the top level.
module rla_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_write_valid,
  input logic       out_heartbeat,
  input logic       out_last,
  input logic [3:0] out_pixel_index
);
  a_last_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |-> !out_write_valid) else $error("last on a pixel word");
  a_hb_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_heartbeat |-> out_last) else $error("heartbeat off marker");
  a_marker_pix: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_write_valid |-> out_pixel_index == 4'd0) else $error("marker pixel");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy && !$past(busy) |-> !out_strobe) else $error("word while idle");
endmodule

bind rotating_led_ring_animator_unit rla_checker u_rla_checker (.*);
